// ===== hdl/lcdsms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdsms_pkg
// Shared types and constants for the LCD scan-line mode sequencer.
// ----------------------------------------------------------------------------
package lcdsms_pkg;

  // Default phase lengths and line counts of the scan timing.
  localparam int SEARCH_CYCLES_DEF   = 80;
  localparam int TRANSFER_CYCLES_DEF = 172;
  localparam int HBLANK_CYCLES_DEF   = 204;
  localparam int LINE_CYCLES_DEF     = 456;
  localparam int VISIBLE_LINES_DEF   = 144;
  localparam int TOTAL_LINES_DEF     = 154;

  // Field widths.
  localparam int CYCLES_W = 6;
  localparam int COUNT_W  = 10;
  localparam int LINE_W   = 8;
  localparam int PHASE_W  = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  // Accumulator ceiling.
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Phase codes as seen on the result stream.
  localparam logic [PHASE_W-1:0] PH_HBLANK   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_VBLANK   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_SEARCH   = 2'd2;
  localparam logic [PHASE_W-1:0] PH_TRANSFER = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_LINE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HBLANK_IRQ_EN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_IRQ_EN = 8'd2;

  // Sequencer state, one-hot.
  typedef enum logic [3:0] {
    ST_HBLANK   = 4'b0001,
    ST_VBLANK   = 4'b0010,
    ST_SEARCH   = 4'b0100,
    ST_TRANSFER = 4'b1000
  } state_t;

  // One result item.
  typedef struct packed {
    logic [LINE_W-1:0]  render_index;
    logic               render_line;
    logic               vblank_irq;
    logic               status_irq;
    logic               compare_match;
    logic [LINE_W-1:0]  line;
    logic [PHASE_W-1:0] phase;
  } result_t;

endpackage

// ===== hdl/lcd_scanline_mode_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_scanline_mode_sequencer_unit
// Steps an LCD controller through line search, pixel transfer, horizontal
// blank and vertical blank from a stream of elapsed-cycle ticks.
// ----------------------------------------------------------------------------
// Each request on the input stream carries the number of clock cycles that
// have elapsed since the previous one. The block adds them to a saturating
// 10-bit accumulator and, when the current phase has run its length, moves to
// the next phase and subtracts that length; at most one phase change happens
// per request. Every input request produces exactly one result request,
// carrying the phase, the line counter, the line-compare flag and the pulses
// for status interrupt, vertical-blank interrupt, line render (with its index)
// and frame done (on tlast). The block takes one request per clock cycle
// while the result stream does not stall, and the result appears in the
// cycle after acceptance: the whole update is a single add, compare and
// subtract between the state registers and the output register, which
// lets a new request in whenever it is empty or being drained in the same
// cycle. Configuration is written through its own channel, which is always
// ready, and should only be changed while no request is in flight.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_sequencer_unit
  import lcdsms_pkg::*;
#(
  parameter int SEARCH_CYCLES   = SEARCH_CYCLES_DEF,
  parameter int TRANSFER_CYCLES = TRANSFER_CYCLES_DEF,
  parameter int HBLANK_CYCLES   = HBLANK_CYCLES_DEF,
  parameter int LINE_CYCLES     = LINE_CYCLES_DEF,
  parameter int VISIBLE_LINES   = VISIBLE_LINES_DEF,
  parameter int TOTAL_LINES     = TOTAL_LINES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Tick stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [5:0] cycles, [7:6] zero
  // Result stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [1:0] phase, [9:2] line,
                                           // [10] compare_match,
                                           // [11] status_irq, [12] vblank_irq,
                                           // [13] render_line,
                                           // [21:14] render_index, [23:22] zero
  output logic                  m_tlast    // frame_done
);

  // Phase lengths and line limits at the widths of the counters they meet.
  localparam logic [COUNT_W-1:0] SEARCH_LEN   = COUNT_W'(SEARCH_CYCLES);
  localparam logic [COUNT_W-1:0] TRANSFER_LEN = COUNT_W'(TRANSFER_CYCLES);
  localparam logic [COUNT_W-1:0] HBLANK_LEN   = COUNT_W'(HBLANK_CYCLES);
  localparam logic [COUNT_W-1:0] LINE_LEN     = COUNT_W'(LINE_CYCLES);
  localparam logic [LINE_W-1:0]  VISIBLE_LIM  = LINE_W'(VISIBLE_LINES);
  localparam logic [LINE_W-1:0]  TOTAL_LIM    = LINE_W'(TOTAL_LINES);

  // Configuration registers.
  logic [LINE_W-1:0] compare_line;
  logic              hblank_irq_enable;
  logic              compare_irq_enable;

  // Sequencer state.
  state_t             state, state_next;
  logic [COUNT_W-1:0] cycle_count, cycle_count_next;
  logic [LINE_W-1:0]  line_count, line_count_next;
  logic               match_flag, match_flag_next;

  // Output register.
  result_t result, result_next;
  logic    frame_done, frame_done_next;

  logic               accept;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] acc;
  logic [LINE_W-1:0]  line_inc;
  logic [PHASE_W-1:0] phase_code;

  assign cfg_ready = 1'b1;

  // A new tick may enter whenever the output register is empty or drains now.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_line       <= '0;
      hblank_irq_enable  <= 1'b0;
      compare_irq_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COMPARE_LINE:   compare_line       <= cfg_data;
        REG_HBLANK_IRQ_EN:  hblank_irq_enable  <= cfg_data[0];
        REG_COMPARE_IRQ_EN: compare_irq_enable <= cfg_data[0];
        default: ;  // unknown indexes are ignored
      endcase
    end
  end

  // The accumulator saturates rather than wrapping.
  assign sum      = {1'b0, cycle_count} + (COUNT_W+1)'(s_tdata[CYCLES_W-1:0]);
  assign acc      = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
  assign line_inc = line_count + LINE_W'(1);

  always_comb begin
    state_next       = state;
    cycle_count_next = acc;
    line_count_next  = line_count;
    match_flag_next  = match_flag;
    result_next      = '0;
    frame_done_next  = 1'b0;

    unique case (state)
      ST_SEARCH: begin
        if (acc >= SEARCH_LEN) begin
          cycle_count_next = acc - SEARCH_LEN;
          state_next       = ST_TRANSFER;
        end
      end
      ST_TRANSFER: begin
        if (acc >= TRANSFER_LEN) begin
          cycle_count_next       = acc - TRANSFER_LEN;
          match_flag_next        = (line_count == compare_line);
          result_next.status_irq = hblank_irq_enable ||
                                   ((line_count == compare_line) && compare_irq_enable);
          state_next             = ST_HBLANK;
        end
      end
      ST_HBLANK: begin
        if (acc >= HBLANK_LEN) begin
          cycle_count_next         = acc - HBLANK_LEN;
          result_next.render_line  = 1'b1;
          result_next.render_index = line_count;
          line_count_next          = line_inc;
          if (line_inc < VISIBLE_LIM) begin
            state_next = ST_SEARCH;
          end else begin
            result_next.vblank_irq = 1'b1;
            state_next             = ST_VBLANK;
          end
        end
      end
      ST_VBLANK: begin
        if (acc >= LINE_LEN) begin
          cycle_count_next = acc - LINE_LEN;
          line_count_next  = line_inc;
          if (line_inc >= TOTAL_LIM) begin
            frame_done_next = 1'b1;
            line_count_next = '0;
            state_next      = ST_SEARCH;
          end
        end
      end
      default: state_next = ST_SEARCH;
    endcase

    unique case (state_next)
      ST_HBLANK:   phase_code = PH_HBLANK;
      ST_VBLANK:   phase_code = PH_VBLANK;
      ST_SEARCH:   phase_code = PH_SEARCH;
      ST_TRANSFER: phase_code = PH_TRANSFER;
      default:     phase_code = PH_SEARCH;
    endcase

    result_next.phase         = phase_code;
    result_next.line          = line_count_next;
    result_next.compare_match = match_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SEARCH;
      cycle_count <= '0;
      line_count  <= '0;
      match_flag  <= 1'b0;
    end else if (accept) begin
      state       <= state_next;
      cycle_count <= cycle_count_next;
      line_count  <= line_count_next;
      match_flag  <= match_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result     <= result_next;
      frame_done <= frame_done_next;
    end
  end

  assign m_tdata = OUT_DATA_W'(result);
  assign m_tlast = frame_done;

`ifndef NO_ASSERTIONS
  // A finished visible line always leads into line search or vertical blank.
  a_render_phase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.render_line |->
      (result.phase == PH_SEARCH) || (result.phase == PH_VBLANK))
    else $error("render pulse with unexpected phase");

  // The vertical-blank interrupt only comes with the last visible line.
  a_vblank_render: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.vblank_irq |-> result.render_line &&
      (result.phase == PH_VBLANK))
    else $error("vblank interrupt without line render");

  // Frame done restarts the frame at line zero in line search.
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && frame_done |-> (result.line == '0) && (result.phase == PH_SEARCH))
    else $error("frame done without restart");

  // The render index is zero whenever no line is rendered.
  a_index_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !result.render_line |-> result.render_index == '0)
    else $error("render index set without render pulse");

  // The accumulator only changes when a tick is taken.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(cycle_count))
    else $error("cycle count moved without a tick");
`endif

endmodule

// ===== verif/lcd_scanline_mode_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_scanline_mode_sequencer_unit_tb
// Self-checking bench for the LCD scan-line mode sequencer.
// ----------------------------------------------------------------------------
// Elapsed-cycle ticks are streamed into the sequencer while a scan-timing
// mirror kept in the bench works out the phase, line counter, compare flag
// and the interrupt, render and frame-done pulses that each tick must give.
// Every result request is checked field by field against the oldest pending
// expectation. The run opens with a short directed sweep of the tick field
// and the register masking, then spends most of its ticks in long random
// stretches of mostly large ticks under several settings, so that a whole
// frame, including vertical blank and the wrap back to line 0, is covered.
// Both streams idle and stall at random, with one stretch kept free of gaps.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_sequencer_unit_tb;
  import lcdsms_pkg::*;

  // One expected result: the packed result fields plus the frame-done pulse,
  // which travels on tlast.
  typedef struct packed {
    result_t res;
    logic    frame_done;
  } scan_expect_t;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every input of the block starts at a known value.
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;  // [5:0] cycles, [7:6] zero
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // [1:0] phase, [9:2] line,
                                          // [10] compare_match,
                                          // [11] status_irq, [12] vblank_irq,
                                          // [13] render_line,
                                          // [21:14] render_index,
                                          // [23:22] zero
  logic                  m_tlast;         // frame_done

  // Scan-timing mirror: its own copy of the sequencer state and registers.
  logic [PHASE_W-1:0] mirror_phase = PH_SEARCH;
  logic [COUNT_W-1:0] mirror_cycles = '0;
  logic [LINE_W-1:0]  mirror_line = '0;
  logic               mirror_match = 1'b0;
  logic [LINE_W-1:0]  cfg_compare_line = '0;
  logic               cfg_hblank_en = 1'b0;
  logic               cfg_compare_en = 1'b0;

  // Results still owed by the block, oldest first.
  scan_expect_t pending_scan[$];

  // When set, neither stream idles nor stalls.
  bit no_gaps = 1'b0;

  int fail_count    = 0;
  int ticks_sent    = 0;
  int results_seen  = 0;
  int frames_seen   = 0;
  int vblanks_seen  = 0;
  int renders_seen  = 0;
  int status_seen   = 0;
  int matches_seen  = 0;
  int settings_used = 0;

  lcd_scanline_mode_sequencer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  // Advances the mirror by one tick and returns the result it must produce.
  // Only one phase change is allowed per tick, and the phase that ends has
  // its length taken off the accumulator.
  function automatic scan_expect_t advance_scan(input logic [CYCLES_W-1:0] ticks);
    scan_expect_t e;
    int unsigned  sum;
    e = '0;
    sum = mirror_cycles + ticks;
    // The accumulator saturates rather than wrapping.
    mirror_cycles = (sum > COUNT_MAX) ? COUNT_MAX : sum[COUNT_W-1:0];
    case (mirror_phase)
      PH_SEARCH: begin
        if (mirror_cycles >= SEARCH_CYCLES_DEF) begin
          mirror_cycles = mirror_cycles - COUNT_W'(SEARCH_CYCLES_DEF);
          mirror_phase = PH_TRANSFER;
        end
      end
      PH_TRANSFER: begin
        if (mirror_cycles >= TRANSFER_CYCLES_DEF) begin
          mirror_cycles = mirror_cycles - COUNT_W'(TRANSFER_CYCLES_DEF);
          // The compare flag is re-evaluated here, set on a match and
          // cleared otherwise; it then holds until the next transfer ends.
          mirror_match = (mirror_line == cfg_compare_line);
          e.res.status_irq = cfg_hblank_en | (mirror_match & cfg_compare_en);
          mirror_phase = PH_HBLANK;
        end
      end
      PH_HBLANK: begin
        if (mirror_cycles >= HBLANK_CYCLES_DEF) begin
          mirror_cycles = mirror_cycles - COUNT_W'(HBLANK_CYCLES_DEF);
          e.res.render_line  = 1'b1;
          e.res.render_index = mirror_line;
          mirror_line = mirror_line + LINE_W'(1);
          if (mirror_line < VISIBLE_LINES_DEF) begin
            mirror_phase = PH_SEARCH;
          end else begin
            e.res.vblank_irq = 1'b1;
            mirror_phase = PH_VBLANK;
          end
        end
      end
      default: begin
        if (mirror_cycles >= LINE_CYCLES_DEF) begin
          mirror_cycles = mirror_cycles - COUNT_W'(LINE_CYCLES_DEF);
          mirror_line = mirror_line + LINE_W'(1);
          // End of frame: back to line 0 and line search.
          if (mirror_line >= TOTAL_LINES_DEF) begin
            e.frame_done = 1'b1;
            mirror_line  = '0;
            mirror_phase = PH_SEARCH;
          end
        end
      end
    endcase
    e.res.phase         = mirror_phase;
    e.res.line          = mirror_line;
    e.res.compare_match = mirror_match;
    return e;
  endfunction

  // A visible line a little ahead of the current one, so that the compare
  // is sure to fire while the next random stretch runs.
  function automatic logic [LINE_W-1:0] line_ahead();
    return LINE_W'((int'(mirror_line) + $urandom_range(1, 24)) % VISIBLE_LINES_DEF);
  endfunction

  // Sends one tick request and records what it must produce. The valid
  // stays high after acceptance so that back-to-back requests need no
  // second assignment in the same step; whoever stops sending lowers it.
  task automatic send_tick(input logic [CYCLES_W-1:0] ticks);
    int           gap;
    scan_expect_t e;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    e = advance_scan(ticks);
    pending_scan = {pending_scan, e};
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - CYCLES_W){1'b0}}, ticks};
    do @(posedge clk); while (!s_tready);
    ticks_sent++;
  endtask

  // Stops sending and waits until every owed result has arrived. Each tick
  // gives exactly one result.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_scan.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes one register; only called while the block is idle. The mirror
  // keeps the bits the register holds and ignores unknown indexes.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_COMPARE_LINE:   cfg_compare_line = val;
      REG_HBLANK_IRQ_EN:  cfg_hblank_en    = val[0];
      REG_COMPARE_IRQ_EN: cfg_compare_en   = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] cmp_line,
                               input logic [CFG_DATA_W-1:0] hb_en,
                               input logic [CFG_DATA_W-1:0] cmp_en);
    wait_drained();
    write_reg(REG_COMPARE_LINE, cmp_line);
    write_reg(REG_HBLANK_IRQ_EN, hb_en);
    write_reg(REG_COMPARE_IRQ_EN, cmp_en);
    settings_used++;
  endtask

  // Random ticks, biased towards large values so that a whole frame goes by
  // within the run. Now and then the sender holds back until the result
  // stream has fully drained.
  task automatic run_ticks(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 199) == 0) wait_drained();
      if ($urandom_range(0, 3) != 0) send_tick(CYCLES_W'($urandom_range(56, 63)));
      else send_tick(CYCLES_W'($urandom_range(0, 63)));
    end
  endtask

  // Directed opening: both extremes of the tick, each tick bit alone and in
  // alternating patterns, a tick landing exactly on the end of line search,
  // a compare match on line 0, and register writes with stray upper bits or
  // unknown indexes that must change nothing.
  task automatic test_directed_start();
    logic [CYCLES_W-1:0] seq[24];
    seq = '{6'd0, 6'd63, 6'd17, 6'd0, 6'd63, 6'd1, 6'd2, 6'd4,
            6'd8, 6'd16, 6'd32, 6'd21, 6'd42, 6'd63, 6'd63, 6'd63,
            6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd62};
    write_reg(REG_COMPARE_IRQ_EN, 8'h01);
    write_reg(REG_HBLANK_IRQ_EN, 8'hFE);
    write_reg(8'd3, 8'hFF);
    write_reg(8'hFF, 8'hAA);
    settings_used++;
    foreach (seq[i]) send_tick(seq[i]);
  endtask

  // Horizontal-blank interrupt on every line; compare line out of reach.
  task automatic test_hblank_irq();
    apply_setting(8'hFF, 8'h01, 8'h01);
    run_ticks(300);
  endtask

  // Compare interrupt alone, aimed at a line that is about to be scanned.
  task automatic test_compare_ahead();
    apply_setting(line_ahead(), 8'h00, 8'h01);
    run_ticks(300);
  endtask

  // Compare on the last visible line with its interrupt masked.
  task automatic test_last_visible_line();
    apply_setting(8'(VISIBLE_LINES_DEF - 1), 8'h01, 8'h00);
    run_ticks(300);
  endtask

  // No idling on either stream: a request every cycle.
  task automatic test_back_to_back();
    apply_setting(line_ahead(), 8'h01, 8'h01);
    no_gaps = 1'b1;
    run_ticks(250);
    no_gaps = 1'b0;
  endtask

  // Random register values, full bytes for the enables.
  task automatic test_random_settings();
    for (int r = 0; r < 3; r++) begin
      apply_setting(($urandom_range(0, 1) != 0) ? line_ahead()
                                                : 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      run_ticks(200);
    end
  endtask

  // Result side: the receiver stalls at random, mostly briefly.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Every accepted result is held against the oldest expectation.
  always @(posedge clk) begin : result_checker
    result_t      got;
    scan_expect_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(result_t)-1:0];
      if (pending_scan.size() == 0) begin
        $error("result arrived with none expected");
        fail_count++;
      end else begin
        want = pending_scan.pop_front();
        results_seen++;
        frames_seen  += want.frame_done;
        vblanks_seen += want.res.vblank_irq;
        renders_seen += want.res.render_line;
        status_seen  += want.res.status_irq;
        matches_seen += want.res.compare_match;
        check_field("phase", 8'(want.res.phase), 8'(got.phase));
        check_field("line", want.res.line, got.line);
        check_field("compare_match", 8'(want.res.compare_match), 8'(got.compare_match));
        check_field("status_irq", 8'(want.res.status_irq), 8'(got.status_irq));
        check_field("vblank_irq", 8'(want.res.vblank_irq), 8'(got.vblank_irq));
        check_field("render_line", 8'(want.res.render_line), 8'(got.render_line));
        check_field("render_index", want.res.render_index, got.render_index);
        check_field("frame_done", 8'(want.frame_done), 8'(m_tlast));
      end
    end
  end

  // Main sequence.
  initial begin
    int guard;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_start();
    test_hblank_irq();
    test_compare_ahead();
    test_last_visible_line();
    test_back_to_back();
    test_random_settings();

    // Let the last results drain, with a bound, then idle before the final check.
    s_tvalid <= 1'b0;
    guard = 0;
    while (pending_scan.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (5) @(posedge clk);
    if (pending_scan.size() != 0) begin
      $error("%0d expected results never arrived", pending_scan.size());
      fail_count++;
    end

    $display("Checked %0d results from %0d ticks under %0d register settings.",
             results_seen, ticks_sent, settings_used);
    $display("Saw %0d frame ends, %0d vblank entries, %0d rendered lines, %0d status irqs, %0d results with compare set.",
             frames_seen, vblanks_seen, renders_seen, status_seen, matches_seen);
    if (fail_count == 0) begin
      $display("[lcd_scanline_mode_sequencer_unit] OK");
    end else begin
      $display("[lcd_scanline_mode_sequencer_unit] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Timed out with %0d results outstanding.", pending_scan.size());
    $display("[lcd_scanline_mode_sequencer_unit] ERROR");
    $finish;
  end

endmodule
